>>> rtl/uv_sphere_mesh_generator_core_macros.svh
// assertion helpers for the sphere generator core
`ifndef UV_SPHERE_MESH_GENERATOR_CORE_MACROS_SVH
`define UV_SPHERE_MESH_GENERATOR_CORE_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define SMG_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on the rising clock, off during reset
`define SMG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/smg_pkg.sv
package smg_pkg;

   // field widths
   localparam int SECTOR_W = 8;
   localparam int RADIUS_W = 16;
   localparam int NUM_W    = 17;
   localparam int COORD_W  = 17;
   localparam int IDX_W    = 16;

   // sector count limits
   localparam logic [SECTOR_W-1:0] MIN_SECTORS = 8'd3;
   localparam logic [SECTOR_W-1:0] MAX_SECTORS = 8'd255;

   // fixed point setup
   localparam int COORD_FRAC_BITS     = 8;
   localparam int TRIG_ITERATIONS_DEF = 16;
   localparam int ATAN_ENTRIES        = 24;

   // register indexes on the csr port
   localparam logic REG_SECTOR_COUNT  = 1'b0;
   localparam logic REG_SPHERE_RADIUS = 1'b1;

   // divider chain sizes
   localparam int DIV1_RW = 8;
   localparam int DIV1_LW = 17;
   localparam int DIV2_RW = 10;
   localparam int DIV2_LW = 32;

   // cordic datapath
   localparam int CX_W = 33;
   localparam int CZ_W = 34;
   localparam logic signed [CX_W-1:0] CORDIC_GAIN = 33'sd652032874;

   localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   // products carry 38 fraction bits
   localparam int PROD_W  = 49;
   localparam int COORD_SH = 38 - COORD_FRAC_BITS;
   localparam logic [PROD_W:0] COORD_BIAS =
      {{(PROD_W-COORD_SH+1){1'b0}}, 1'b1, {(COORD_SH-1){1'b0}}};
   localparam logic signed [PROD_W:0] COORD_MAX = (PROD_W+1)'(65535);
   localparam logic signed [PROD_W:0] COORD_MIN = -COORD_MAX;

   typedef struct packed {
      logic                   flip;
      logic signed [CX_W-1:0] x;
      logic signed [CX_W-1:0] y;
      logic signed [CZ_W-1:0] z;
   } cordic_type;

   typedef enum logic [1:0] {
      REGION_NORTH,
      REGION_BAND,
      REGION_SOUTH
   } region_type;

   // item info riding along the first divider
   typedef struct packed {
      logic                valid;
      logic                op;
      logic                oor;
      logic                npole;
      logic                spole;
      region_type          region;
      logic                odd;
      logic [SECTOR_W-1:0] fan_pos;
   } side1_type;

   // item info riding along the rest of the pipe
   typedef struct packed {
      logic             valid;
      logic             op;
      logic             oor;
      logic             npole;
      logic             spole;
      logic [IDX_W-1:0] corner_a;
      logic [IDX_W-1:0] corner_b;
      logic [IDX_W-1:0] corner_c;
   } side2_type;

   // round q2.30 to q1.15 half up, saturate
   function automatic logic signed [15:0] round_q15(input logic signed [CX_W-1:0] v);
      logic signed [CX_W:0] t;
      logic signed [CX_W:0] s;
      t = $signed({v[CX_W-1], v}) + $signed((CX_W+1)'(16384));
      s = t >>> 15;
      if (s > $signed((CX_W+1)'(32767))) begin
         return 16'sh7FFF;
      end else if (s < -$signed((CX_W+1)'(32768))) begin
         return 16'sh8000;
      end
      return s[15:0];
   endfunction

   // 38 fraction bits to output coordinate, round half up, saturate
   function automatic logic signed [COORD_W-1:0] to_coord(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W:0] t;
      logic signed [PROD_W:0] s;
      t = $signed({v[PROD_W-1], v}) + $signed(COORD_BIAS);
      s = t >>> COORD_SH;
      if (s > COORD_MAX) begin
         return COORD_MAX[COORD_W-1:0];
      end else if (s < COORD_MIN) begin
         return COORD_MIN[COORD_W-1:0];
      end
      return s[COORD_W-1:0];
   endfunction

endpackage

>>> rtl/uv_sphere_mesh_generator_core.sv
// UV sphere mesh generator: each request item (tuser = 0 for a vertex, 1 for a
// triangle; tdata = item number) gives one result item with a Q8.8 position or
// three vertex indices, plus an out-of-range flag in tuser. The block is a
// fixed pipeline that takes one item every cycle while no result is held on
// the output. It is made of one input stage, a 17-cell divider
// that splits the number by the sector count, two 32-cell dividers that form
// the polar and azimuth phases, one CORDIC cell per iteration, three
// rounding and multiply stages and the output register. When a result is
// held on the output the whole pipeline holds with it. Registers: sector
// count at 0x0, radius at 0x4; write them only while the pipeline is empty.
`include "uv_sphere_mesh_generator_core_macros.svh"

module uv_sphere_mesh_generator_core #(
   parameter int TRIG_ITERATIONS = smg_pkg::TRIG_ITERATIONS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,   // item_number[16:0], zero fill
   input  logic [0:0]   req_tuser,   // op[0]
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // pos_x, pos_y, pos_z, corner_a, corner_b,
                                     // corner_c, zero fill
   output logic [0:0]   rsp_tuser,   // out_of_range[0]
   // register port
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int D1 = smg_pkg::DIV1_LW;
   localparam int D2 = smg_pkg::DIV2_LW + TRIG_ITERATIONS + 3;
   localparam int SW = smg_pkg::SECTOR_W;
   localparam int NW = smg_pkg::NUM_W;
   localparam int IW = smg_pkg::IDX_W;
   localparam int CW = smg_pkg::CX_W;
   localparam int PW = smg_pkg::PROD_W;

   // configuration registers
   logic [SW-1:0]                 sector_count_ff;
   logic [smg_pkg::RADIUS_W-1:0]  sphere_radius_ff;
   logic                          csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         sector_count_ff  <= 8'd80;
         sphere_radius_ff <= 16'd256;
      end else if (csr_write) begin
         case (csr_paddr[2])
            smg_pkg::REG_SECTOR_COUNT:  sector_count_ff  <= csr_pwdata[SW-1:0];
            smg_pkg::REG_SPHERE_RADIUS: sphere_radius_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         smg_pkg::REG_SECTOR_COUNT:  csr_prdata = {24'd0, sector_count_ff};
         smg_pkg::REG_SPHERE_RADIUS: csr_prdata = {16'd0, sphere_radius_ff};
         default:                    csr_prdata = 32'd0;
      endcase
   end

   // mesh sizes from the clamped sector count
   logic [SW-1:0] qc;
   logic [NW-1:0] qq;
   logic [NW-1:0] nvert, ntri;
   logic [IW-1:0] last;

   always_comb begin
      if (sector_count_ff < smg_pkg::MIN_SECTORS) begin
         qc = smg_pkg::MIN_SECTORS;
      end else if (sector_count_ff > smg_pkg::MAX_SECTORS) begin
         qc = smg_pkg::MAX_SECTORS;
      end else begin
         qc = sector_count_ff;
      end
      qq    = NW'(qc * ({1'b0, qc} + 9'd1));
      nvert = qq + NW'(2);
      ntri  = {qq[NW-2:0], 1'b0};
      last  = IW'(qq + NW'(1));
   end

   // global advance: the pipe moves unless a result is held
   logic en;
   logic rsp_valid_ff;

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   // input stage
   logic          s0_valid_ff;
   logic          s0_op_ff;
   logic [NW-1:0] s0_num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_op_ff  <= req_tuser[0];
         s0_num_ff <= req_tdata[NW-1:0];
      end
   end

   // decode the number and pick the first dividend
   smg_pkg::side1_type side1_in;
   logic [NW-1:0]      dvd1;
   logic [NW-1:0]      south_start, m_band, n_south;

   always_comb begin
      south_start     = ntri - NW'(qc);
      m_band          = s0_num_ff - NW'(qc);
      n_south         = s0_num_ff - south_start;
      side1_in.valid  = s0_valid_ff;
      side1_in.op     = s0_op_ff;
      side1_in.oor    = s0_op_ff ? (s0_num_ff >= ntri) : (s0_num_ff >= nvert);
      side1_in.npole  = (s0_num_ff == '0);
      side1_in.spole  = (s0_num_ff == NW'(last));
      side1_in.odd    = m_band[0];
      if (s0_num_ff < NW'(qc)) begin
         side1_in.region  = smg_pkg::REGION_NORTH;
         side1_in.fan_pos = s0_num_ff[SW-1:0];
      end else if (s0_num_ff >= south_start) begin
         side1_in.region  = smg_pkg::REGION_SOUTH;
         side1_in.fan_pos = n_south[SW-1:0];
      end else begin
         side1_in.region  = smg_pkg::REGION_BAND;
         side1_in.fan_pos = n_south[SW-1:0];
      end
      dvd1 = s0_op_ff ? {1'b0, m_band[NW-1:1]} : (s0_num_ff - NW'(1));
   end

   // first divider: number by sector count
   logic [smg_pkg::DIV1_RW-1:0] d1_rem  [D1+1];
   logic [smg_pkg::DIV1_LW-1:0] d1_work [D1+1];
   smg_pkg::side1_type          side1_ff [D1];

   assign d1_rem[0]  = '0;
   assign d1_work[0] = dvd1;

   for (genvar k = 0; k < D1; k++) begin : g_div1
      smg_div_cell #(.RW(smg_pkg::DIV1_RW), .LW(smg_pkg::DIV1_LW)) u_cell (
         .clock   (clock),
         .en      (en),
         .divisor (qc),
         .rem_i   (d1_rem[k]),
         .work_i  (d1_work[k]),
         .rem_o   (d1_rem[k+1]),
         .work_o  (d1_work[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < D1; k++) side1_ff[k] <= '0;
      end else if (en) begin
         side1_ff[0] <= side1_in;
         for (int k = 1; k < D1; k++) side1_ff[k] <= side1_ff[k-1];
      end
   end

   // triangle corners and phase dividends
   smg_pkg::side1_type  sd1;
   smg_pkg::side2_type  side2_in;
   logic [SW-1:0]       quo, rmd, jn, sm1;
   logic [SW:0]         jp1, np1;
   logic [IW-1:0]       base, ca, cb, cc;
   logic [smg_pkg::DIV2_RW-1:0] den, pa_rem0, pb_rem0, pb_div;
   logic [smg_pkg::DIV2_LW-1:0] pa_work0, pb_work0;

   always_comb begin
      sd1  = side1_ff[D1-1];
      // ring and band row never exceed the sector count
      quo  = d1_work[D1][SW-1:0];
      rmd  = d1_rem[D1];
      jp1  = {1'b0, rmd} + 9'd1;
      jn   = (jp1 == {1'b0, qc}) ? 8'd0 : jp1[SW-1:0];
      np1  = {1'b0, sd1.fan_pos} + 9'd1;
      sm1  = (np1 == {1'b0, qc}) ? 8'd0 : np1[SW-1:0];
      base = IW'(quo * qc) + IW'(1);
      case (sd1.region)
         smg_pkg::REGION_NORTH: begin
            ca = '0;
            cb = IW'(sd1.fan_pos) + IW'(1);
            cc = (sd1.fan_pos == qc - 8'd1) ? IW'(1) : IW'(sd1.fan_pos) + IW'(2);
         end
         smg_pkg::REGION_SOUTH: begin
            ca = last;
            cb = last - IW'(1) - IW'(sd1.fan_pos);
            cc = last - IW'(1) - IW'(sm1);
         end
         default: begin
            ca = base + IW'(rmd);
            if (!sd1.odd) begin
               cb = base + IW'(qc) + IW'(rmd);
               cc = base + IW'(qc) + IW'(jn);
            end else begin
               cb = base + IW'(qc) + IW'(jn);
               cc = base + IW'(jn);
            end
         end
      endcase
      side2_in.valid = sd1.valid;
      side2_in.op    = sd1.op;
      side2_in.oor   = sd1.oor;
      side2_in.npole = sd1.npole;
      side2_in.spole = sd1.spole;
      if (sd1.op && !sd1.oor) begin
         side2_in.corner_a = ca;
         side2_in.corner_b = cb;
         side2_in.corner_c = cc;
      end else begin
         side2_in.corner_a = '0;
         side2_in.corner_b = '0;
         side2_in.corner_c = '0;
      end
      den      = {1'b0, {1'b0, qc} + 9'd2} << 1;
      pa_rem0  = smg_pkg::DIV2_RW'({1'b0, quo} + 9'd1);
      pa_work0 = smg_pkg::DIV2_LW'({1'b0, qc} + 9'd2);
      pb_div   = smg_pkg::DIV2_RW'(qc);
      pb_rem0  = smg_pkg::DIV2_RW'(rmd);
      pb_work0 = smg_pkg::DIV2_LW'(qc >> 1);
   end

   // phase dividers: polar and azimuth, one quotient bit per cell
   logic [smg_pkg::DIV2_RW-1:0] pa_rem  [smg_pkg::DIV2_LW+1];
   logic [smg_pkg::DIV2_LW-1:0] pa_work [smg_pkg::DIV2_LW+1];
   logic [smg_pkg::DIV2_RW-1:0] pb_rem  [smg_pkg::DIV2_LW+1];
   logic [smg_pkg::DIV2_LW-1:0] pb_work [smg_pkg::DIV2_LW+1];

   assign pa_rem[0]  = pa_rem0;
   assign pa_work[0] = pa_work0;
   assign pb_rem[0]  = pb_rem0;
   assign pb_work[0] = pb_work0;

   for (genvar k = 0; k < smg_pkg::DIV2_LW; k++) begin : g_div2
      smg_div_cell #(.RW(smg_pkg::DIV2_RW), .LW(smg_pkg::DIV2_LW)) u_pa (
         .clock   (clock),
         .en      (en),
         .divisor (den),
         .rem_i   (pa_rem[k]),
         .work_i  (pa_work[k]),
         .rem_o   (pa_rem[k+1]),
         .work_o  (pa_work[k+1])
      );
      smg_div_cell #(.RW(smg_pkg::DIV2_RW), .LW(smg_pkg::DIV2_LW)) u_pb (
         .clock   (clock),
         .en      (en),
         .divisor (pb_div),
         .rem_i   (pb_rem[k]),
         .work_i  (pb_work[k]),
         .rem_o   (pb_rem[k+1]),
         .work_o  (pb_work[k+1])
      );
   end

   // fold phases into the right half plane and seed the rotators
   smg_pkg::cordic_type cra [TRIG_ITERATIONS+1];
   smg_pkg::cordic_type crb [TRIG_ITERATIONS+1];
   logic [31:0]         pa, pb, pa_f, pb_f;
   logic                fa, fb;

   always_comb begin
      pa   = pa_work[smg_pkg::DIV2_LW];
      pb   = pb_work[smg_pkg::DIV2_LW];
      fa   = pa[31] ^ pa[30];
      fb   = pb[31] ^ pb[30];
      pa_f = fa ? {~pa[31], pa[30:0]} : pa;
      pb_f = fb ? {~pb[31], pb[30:0]} : pb;
      cra[0].flip = fa;
      cra[0].x    = smg_pkg::CORDIC_GAIN;
      cra[0].y    = '0;
      cra[0].z    = $signed({{(smg_pkg::CZ_W-32){pa_f[31]}}, pa_f});
      crb[0].flip = fb;
      crb[0].x    = smg_pkg::CORDIC_GAIN;
      crb[0].y    = '0;
      crb[0].z    = $signed({{(smg_pkg::CZ_W-32){pb_f[31]}}, pb_f});
   end

   for (genvar k = 0; k < TRIG_ITERATIONS; k++) begin : g_cordic
      smg_cordic_cell #(.STAGE(k)) u_a (
         .clock   (clock),
         .en      (en),
         .state_i (cra[k]),
         .state_o (cra[k+1])
      );
      smg_cordic_cell #(.STAGE(k)) u_b (
         .clock   (clock),
         .en      (en),
         .state_i (crb[k]),
         .state_o (crb[k+1])
      );
   end

   // unfold and round to q1.15
   logic signed [CW-1:0] xa, ya, xb, yb;
   logic signed [15:0]   sa_ff, ca_ff, sb_ff, cb_ff;

   always_comb begin
      xa = cra[TRIG_ITERATIONS].flip ? -cra[TRIG_ITERATIONS].x : cra[TRIG_ITERATIONS].x;
      ya = cra[TRIG_ITERATIONS].flip ? -cra[TRIG_ITERATIONS].y : cra[TRIG_ITERATIONS].y;
      xb = crb[TRIG_ITERATIONS].flip ? -crb[TRIG_ITERATIONS].x : crb[TRIG_ITERATIONS].x;
      yb = crb[TRIG_ITERATIONS].flip ? -crb[TRIG_ITERATIONS].y : crb[TRIG_ITERATIONS].y;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sa_ff <= smg_pkg::round_q15(ya);
         ca_ff <= smg_pkg::round_q15(xa);
         sb_ff <= smg_pkg::round_q15(yb);
         cb_ff <= smg_pkg::round_q15(xb);
      end
   end

   // radius times polar terms
   logic signed [32:0] xz_ff, yv_ff;
   logic signed [15:0] sb2_ff, cb2_ff;
   logic signed [16:0] r_s;

   assign r_s = $signed({1'b0, sphere_radius_ff});

   always_ff @(posedge clock) begin
      if (en) begin
         xz_ff  <= r_s * sa_ff;
         yv_ff  <= r_s * ca_ff;
         sb2_ff <= sb_ff;
         cb2_ff <= cb_ff;
      end
   end

   // azimuth terms, all products at 38 fraction bits
   logic signed [PW-1:0] px_ff, py_ff, pz_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= xz_ff * sb2_ff;
         pz_ff <= xz_ff * cb2_ff;
         py_ff <= $signed({yv_ff[32], yv_ff, 15'd0});
      end
   end

   // item info for the long part of the pipe
   smg_pkg::side2_type side2_ff [D2];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < D2; k++) side2_ff[k] <= '0;
      end else if (en) begin
         side2_ff[0] <= side2_in;
         for (int k = 1; k < D2; k++) side2_ff[k] <= side2_ff[k-1];
      end
   end

   // result assembly
   smg_pkg::side2_type   sd2;
   logic signed [PW-1:0] pole;
   logic [smg_pkg::COORD_W-1:0] ox, oy, oz;
   logic [103:0]         rsp_data_ff, rsp_data_in;
   logic                 rsp_oor_ff;

   always_comb begin
      sd2  = side2_ff[D2-1];
      pole = $signed({3'd0, sphere_radius_ff, 30'd0});
      ox   = '0;
      oy   = '0;
      oz   = '0;
      if (!sd2.op && !sd2.oor) begin
         if (sd2.npole) begin
            oy = smg_pkg::to_coord(pole);
         end else if (sd2.spole) begin
            oy = smg_pkg::to_coord(-pole);
         end else begin
            ox = smg_pkg::to_coord(px_ff);
            oy = smg_pkg::to_coord(py_ff);
            oz = smg_pkg::to_coord(pz_ff);
         end
      end
      rsp_data_in = {5'd0, sd2.corner_c, sd2.corner_b, sd2.corner_a, oz, oy, ox};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= sd2.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
         rsp_oor_ff  <= sd2.oor;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_oor_ff;

   // checks
   `SMG_ASSERT_NOW(a_oor_zero, rsp_tvalid && rsp_tuser[0], rsp_tdata == '0,
      "out-of-range result carries data")
   `SMG_ASSERT_NOW(a_pos_xor_tri, rsp_tvalid && (rsp_tdata[50:0] != '0),
      rsp_tdata[98:51] == '0, "result has both position and corners")
   `SMG_ASSERT_NOW(a_corner_bound, rsp_tvalid,
      (rsp_tdata[66:51] <= last) && (rsp_tdata[82:67] <= last) &&
      (rsp_tdata[98:83] <= last), "corner index beyond last vertex")
   `SMG_ASSERT_NEXT(a_accept_lands, req_tvalid && req_tready, s0_valid_ff,
      "accepted item missing from input stage")

endmodule

>>> rtl/smg_div_cell.sv
module smg_div_cell #(
   parameter int RW = smg_pkg::DIV1_RW,
   parameter int LW = smg_pkg::DIV1_LW
) (
   input  logic          clock,
   input  logic          en,
   input  logic [RW-1:0] divisor,
   input  logic [RW-1:0] rem_i,
   input  logic [LW-1:0] work_i,
   output logic [RW-1:0] rem_o,
   output logic [LW-1:0] work_o
);

   logic [RW-1:0] rem_ff, rem_in;
   logic [LW-1:0] work_ff, work_in;
   logic [RW:0]   trial;
   logic [RW:0]   diff;
   logic          ge;

   // one restoring step: dividend bit out the top, quotient bit in the bottom
   always_comb begin
      trial   = {rem_i, work_i[LW-1]};
      diff    = trial - {1'b0, divisor};
      ge      = (trial >= {1'b0, divisor});
      rem_in  = ge ? diff[RW-1:0] : trial[RW-1:0];
      work_in = {work_i[LW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         work_ff <= work_in;
      end
   end

   assign rem_o  = rem_ff;
   assign work_o = work_ff;

endmodule

>>> rtl/smg_cordic_cell.sv
module smg_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic                   clock,
   input  logic                   en,
   input  smg_pkg::cordic_type    state_i,
   output smg_pkg::cordic_type    state_o
);

   smg_pkg::cordic_type state_ff, state_in;
   logic signed [smg_pkg::CX_W-1:0] dx, dy;
   logic signed [smg_pkg::CZ_W-1:0] angle;

   // one micro-rotation toward zero residual angle
   always_comb begin
      dx    = state_i.y >>> STAGE;
      dy    = state_i.x >>> STAGE;
      angle = $signed({{(smg_pkg::CZ_W-32){1'b0}}, smg_pkg::ATAN_TURNS[STAGE]});
      state_in      = state_i;
      if (!state_i.z[smg_pkg::CZ_W-1]) begin
         state_in.x = state_i.x - dx;
         state_in.y = state_i.y + dy;
         state_in.z = state_i.z - angle;
      end else begin
         state_in.x = state_i.x + dx;
         state_in.y = state_i.y - dy;
         state_in.z = state_i.z + angle;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         state_ff <= state_in;
      end
   end

   assign state_o = state_ff;

endmodule
